@@ rtl/core/shdlc_response_frame_decoder_unit_defines.svh @@
// Assertion macros used by the SHDLC response decoder RTL.
// No dependencies; included by the files that carry assertions.
`ifndef SHDLC_RESPONSE_FRAME_DECODER_UNIT_DEFINES_SVH
`define SHDLC_RESPONSE_FRAME_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SHDLC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shdlc assertion failed");

// Next-cycle implication, disabled during reset
`define SHDLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shdlc assertion failed");

`endif

@@ rtl/core/shdlc_pkg.sv @@
// Package for the SHDLC response frame decoder: codes, byte constants and types.
// No dependencies.
package shdlc_pkg;

  // Framing and stuffing bytes
  localparam logic [7:0] FLAG_BYTE   = 8'h7E;
  localparam logic [7:0] ESC_BYTE    = 8'h7D;
  localparam logic [7:0] ESC_FLAG    = 8'h5E;
  localparam logic [7:0] ESC_ESC     = 8'h5D;
  localparam logic [7:0] ESC_XON     = 8'h31;
  localparam logic [7:0] ESC_XOFF    = 8'h33;
  // flow-control characters DC1 and DC3
  localparam logic [7:0] DC1_BYTE    = 8'h11;
  localparam logic [7:0] DC3_BYTE    = 8'h13;
  localparam logic [7:0] INV_MASK    = 8'hFF;
  localparam logic [7:0] ZERO_BYTE   = 8'h00;

  localparam int unsigned CNT_W      = 10;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Result queue geometry
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned FCNT_W     = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_DELIM = 3'd1,
    ST_CSUM      = 3'd2,
    ST_DEV_STATE = 3'd3,
    ST_SHORT     = 3'd4
  } frame_status_t;

  typedef enum logic {
    KIND_DATA    = 1'b0,
    KIND_SUMMARY = 1'b1
  } item_kind_t;

  typedef struct packed {
    logic [0:0] item_kind;
    logic [7:0] data_byte;
    logic [7:0] slave_address;
    logic [7:0] command_id;
    logic [7:0] device_state;
    logic [7:0] payload_length;
    logic [2:0] frame_status;
  } result_t;

  // Up to two results produced by one input byte, packed from slot 0
  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } result_pair_t;

endpackage

@@ rtl/core/shdlc_if.sv @@
// Valid/ready channel interfaces for the SHDLC response decoder.
// Depends on nothing; payload widths follow the frame fields.
interface shdlc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic [0:0] frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface shdlc_out_if;
  logic       valid;
  logic       ready;
  logic [0:0] item_kind;
  logic [7:0] data_byte;
  logic [7:0] slave_address;
  logic [7:0] command_id;
  logic [7:0] device_state;
  logic [7:0] payload_length;
  logic [2:0] frame_status;

  modport source (output valid, output item_kind, output data_byte, output slave_address,
                  output command_id, output device_state, output payload_length,
                  output frame_status, input ready);
  modport sink   (input valid, input item_kind, input data_byte, input slave_address,
                  input command_id, input device_state, input payload_length,
                  input frame_status, output ready);
endinterface

@@ rtl/core/shdlc_decode_core.sv @@
// Frame state and per-byte decode step: unstuffing, header capture, checksum, summary.
// Depends on shdlc_pkg.
module shdlc_decode_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic [7:0]           rx_byte,
  input  logic                 frame_end,
  output shdlc_pkg::result_pair_t res
);

  typedef struct packed {
    logic                        esc;
    logic                        in_frame;
    logic                        open_ok;
    logic [shdlc_pkg::CNT_W-1:0] cnt;
    logic [7:0]                  sum;
    logic [7:0]                  prev;
    logic [7:0]                  addr;
    logic [7:0]                  cmd;
    logic [7:0]                  dst;
    logic [7:0]                  len;
  } st_t;

  typedef struct packed {
    st_t        s;
    logic       emit;
    logic [7:0] data;
  } push_t;

  st_t state_r, state_nxt;

  // Clear everything but the framing flag
  function automatic st_t clear_frame(st_t s);
    st_t c;
    c          = '0;
    c.in_frame = s.in_frame;
    return c;
  endfunction

  // Append one unstuffed byte; the previous byte goes out if it lies in the data block
  function automatic push_t push_byte(st_t s, logic [7:0] b);
    push_t p;
    p      = '0;
    p.s    = s;
    p.data = s.prev;
    p.emit = (s.cnt >= shdlc_pkg::CNT_W'(5)) &&
             ({1'b0, s.cnt} < (11'd5 + {3'b000, s.len}));
    case (s.cnt)
      shdlc_pkg::CNT_W'(0): p.s.addr = b;
      shdlc_pkg::CNT_W'(1): p.s.cmd  = b;
      shdlc_pkg::CNT_W'(2): p.s.dst  = b;
      shdlc_pkg::CNT_W'(3): p.s.len  = b;
      default: ;
    endcase
    p.s.sum  = s.sum + b;
    p.s.prev = b;
    if (s.cnt != shdlc_pkg::CNT_MAX) begin
      p.s.cnt = s.cnt + shdlc_pkg::CNT_W'(1);
    end
    return p;
  endfunction

  function automatic shdlc_pkg::result_t data_res(logic [7:0] d);
    shdlc_pkg::result_t r;
    r           = '0;
    r.item_kind = shdlc_pkg::KIND_DATA;
    r.data_byte = d;
    return r;
  endfunction

  // Decode step
  always_comb begin
    st_t                s;
    push_t              pa, pb;
    logic               use_a, use_b, do_sum;
    logic [7:0]         b_a, b_b, content;
    shdlc_pkg::result_t ra, rb, rs;
    logic               ea, eb;

    s      = state_r;
    use_a  = 1'b0;
    use_b  = 1'b0;
    b_a    = '0;
    b_b    = '0;
    do_sum = 1'b0;

    if (!state_r.in_frame) begin
      // opening byte starts a fresh frame
      s          = clear_frame(state_r);
      s.open_ok  = (rx_byte == shdlc_pkg::FLAG_BYTE);
      s.in_frame = 1'b1;
      do_sum     = frame_end;
    end else if (!frame_end) begin
      if (state_r.esc) begin
        s.esc = 1'b0;
        use_a = 1'b1;
        case (rx_byte)
          shdlc_pkg::ESC_FLAG: b_a = shdlc_pkg::FLAG_BYTE;
          shdlc_pkg::ESC_ESC:  b_a = shdlc_pkg::ESC_BYTE;
          shdlc_pkg::ESC_XON:  b_a = shdlc_pkg::DC1_BYTE;
          shdlc_pkg::ESC_XOFF: b_a = shdlc_pkg::DC3_BYTE;
          default: begin
            // unknown escape: keep the 7D, then the byte itself
            b_a = shdlc_pkg::ESC_BYTE;
            if (rx_byte == shdlc_pkg::ESC_BYTE) begin
              s.esc = 1'b1;
            end else begin
              use_b = 1'b1;
              b_b   = rx_byte;
            end
          end
        endcase
      end else if (rx_byte == shdlc_pkg::ESC_BYTE) begin
        s.esc = 1'b1;
      end else begin
        use_a = 1'b1;
        b_a   = rx_byte;
      end
    end else begin
      // closing byte: flush a dangling escape as a plain 7D
      if (state_r.esc) begin
        s.esc = 1'b0;
        use_a = 1'b1;
        b_a   = shdlc_pkg::ESC_BYTE;
      end
      do_sum = 1'b1;
    end

    pa = push_byte(s, b_a);
    if (use_a) begin
      s = pa.s;
    end
    pb = push_byte(s, b_b);
    if (use_b) begin
      s = pb.s;
    end
    ea = use_a && pa.emit;
    eb = use_b && pb.emit;
    ra = data_res(pa.data);
    rb = data_res(pb.data);

    // End-of-frame summary with status priority
    content           = s.sum - s.prev;
    rs                = '0;
    rs.item_kind      = shdlc_pkg::KIND_SUMMARY;
    rs.slave_address  = s.addr;
    rs.command_id     = s.cmd;
    rs.device_state   = s.dst;
    rs.payload_length = s.len;
    if (!s.open_ok || (rx_byte != shdlc_pkg::FLAG_BYTE)) begin
      rs.frame_status = shdlc_pkg::ST_BAD_DELIM;
    end else if ({1'b0, s.cnt} < (11'd5 + {3'b000, s.len})) begin
      rs.frame_status = shdlc_pkg::ST_SHORT;
    end else if ((content ^ shdlc_pkg::INV_MASK) != s.prev) begin
      rs.frame_status = shdlc_pkg::ST_CSUM;
    end else if (s.dst != shdlc_pkg::ZERO_BYTE) begin
      rs.frame_status = shdlc_pkg::ST_DEV_STATE;
    end else begin
      rs.frame_status = shdlc_pkg::ST_OK;
    end
    if (do_sum) begin
      s.in_frame = 1'b0;
      s.esc      = 1'b0;
    end

    // Pack results in order from slot 0
    res = '0;
    if (ea) begin
      res.r0 = ra;
      if (eb) begin
        res.r1  = rb;
        res.num = 2'd2;
      end else if (do_sum) begin
        res.r1  = rs;
        res.num = 2'd2;
      end else begin
        res.num = 2'd1;
      end
    end else if (eb) begin
      res.r0  = rb;
      res.num = 2'd1;
    end else if (do_sum) begin
      res.r0  = rs;
      res.num = 2'd1;
    end
    if (!step_en) begin
      res.num = 2'd0;
    end

    state_nxt = s;
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (step_en) begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/core/shdlc_result_fifo.sv @@
// Result queue: takes up to two results a cycle, hands out one a cycle while rd_ready is high.
// Depends on shdlc_pkg and the assertion macro header.
`include "shdlc_response_frame_decoder_unit_defines.svh"
module shdlc_result_fifo (
  input  logic                     clk,
  input  logic                     rst_n,
  input  shdlc_pkg::result_pair_t  wr,
  output logic                     space_ok,
  output logic                     rd_valid,
  input  logic                     rd_ready,
  output shdlc_pkg::result_t       rd_data
);

  shdlc_pkg::result_t                mem_r [shdlc_pkg::FIFO_DEPTH];
  logic [shdlc_pkg::PTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [shdlc_pkg::FCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                              rd_fire;

  assign rd_valid = (cnt_r != '0);
  assign rd_fire  = rd_valid && rd_ready;
  assign rd_data  = mem_r[rd_ptr_r];
  // room for the worst case of two results from one byte
  assign space_ok = (cnt_r <= shdlc_pkg::FCNT_W'(shdlc_pkg::FIFO_DEPTH - 2));

  always_comb begin
    cnt_nxt = cnt_r + shdlc_pkg::FCNT_W'(wr.num) - shdlc_pkg::FCNT_W'(rd_fire);
  end

  // Storage writes
  always_ff @(posedge clk) begin
    if (wr.num != 2'd0) begin
      mem_r[wr_ptr_r] <= wr.r0;
    end
    if (wr.num == 2'd2) begin
      mem_r[wr_ptr_r + shdlc_pkg::PTR_W'(1)] <= wr.r1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + shdlc_pkg::PTR_W'(wr.num);
      rd_ptr_r <= rd_ptr_r + shdlc_pkg::PTR_W'(rd_fire);
      cnt_r    <= cnt_nxt;
    end
  end

  `SHDLC_ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1,
                     cnt_r <= shdlc_pkg::FCNT_W'(shdlc_pkg::FIFO_DEPTH))
  `SHDLC_ASSERT_IMPL(a_no_overrun, clk, rst_n, wr.num != 2'd0,
                     cnt_r + shdlc_pkg::FCNT_W'(wr.num) <= shdlc_pkg::FCNT_W'(shdlc_pkg::FIFO_DEPTH))
  `SHDLC_ASSERT_NEXT(a_pop_drains, clk, rst_n, rd_fire && (wr.num == 2'd0),
                     cnt_r == $past(cnt_r) - shdlc_pkg::FCNT_W'(1))

endmodule

@@ rtl/core/shdlc_response_frame_decoder_unit.sv @@
// Top level of the SHDLC response frame decoder: input register, decode step, result queue.
// Depends on shdlc_pkg, shdlc_if, shdlc_decode_core and shdlc_result_fifo.
//
//   channel    direction  payload
//   in_chan    sink       rx_byte[7:0], frame_end
//   out_chan   source     item_kind, data_byte, header bytes, frame_status[2:0]
//
// One byte is accepted per cycle unless input stalls; it is held in the input register,
// is decoded there and its zero, one or two results land in a four-entry queue.
// Results are offered in order once written to the queue; input stalls only while the
// queue cannot take two more results (the decode step writes up to two at once).
// Reset (rst_n, synchronous, active low) clears the frame state and empties the queue.
module shdlc_response_frame_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  shdlc_in_if.sink    in_chan,
  shdlc_out_if.source out_chan
);

  logic                    hold_vld_r;
  logic [7:0]              hold_byte_r;
  logic                    hold_end_r;
  logic                    space_ok;
  logic                    step_en;
  logic                    in_fire;
  shdlc_pkg::result_pair_t res;
  shdlc_pkg::result_t      rd_data;

  assign step_en       = hold_vld_r && space_ok;
  assign in_chan.ready = !hold_vld_r || step_en;
  assign in_fire       = in_chan.valid && in_chan.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      hold_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_byte_r <= in_chan.rx_byte;
      hold_end_r  <= in_chan.frame_end[0];
    end
  end

  shdlc_decode_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .rx_byte   (hold_byte_r),
    .frame_end (hold_end_r),
    .res       (res)
  );

  shdlc_result_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (res),
    .space_ok (space_ok),
    .rd_valid (out_chan.valid),
    .rd_ready (out_chan.ready),
    .rd_data  (rd_data)
  );

  // Output transaction payload
  assign out_chan.item_kind      = rd_data.item_kind;
  assign out_chan.data_byte      = rd_data.data_byte;
  assign out_chan.slave_address  = rd_data.slave_address;
  assign out_chan.command_id     = rd_data.command_id;
  assign out_chan.device_state   = rd_data.device_state;
  assign out_chan.payload_length = rd_data.payload_length;
  assign out_chan.frame_status   = rd_data.frame_status;

endmodule

@@ tb/sv/shdlc_response_frame_decoder_unit_tb.sv @@
// Self-checking testbench for shdlc_response_frame_decoder_unit: feeds raw SHDLC response
// bytes, predicts unstuffed data bytes and frame summaries, and checks every transaction.
// Depends on shdlc_pkg, the shdlc_in_if / shdlc_out_if interfaces and the decoder RTL.
module shdlc_response_frame_decoder_unit_tb;

  localparam int DIRECTED_ROWS = 28;
  localparam int RANDOM_ITEMS  = 422;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 16;

  typedef struct {
    logic [7:0]         rx;
    logic               fend;
    bit                 typed;
    shdlc_pkg::result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  shdlc_in_if  in_chan ();
  shdlc_out_if out_chan ();

  shdlc_response_frame_decoder_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // 4-unit clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  shdlc_pkg::result_t awaited_results[$];
  shdlc_pkg::result_t step_results[$];
  int      items_sent  = 0;
  int      mismatches  = 0;
  int      idle_cycles = 0;
  bit      quiet_mode  = 1'b0;

  // Decoder state as the predictor sees it
  logic                        esc_wait;
  logic                        framing;
  logic                        open_good;
  logic [shdlc_pkg::CNT_W-1:0] ucount;
  logic [7:0]                  csum_acc;
  logic [7:0]                  last_byte;
  logic [7:0]                  hdr_addr;
  logic [7:0]                  hdr_cmd;
  logic [7:0]                  hdr_state;
  logic [7:0]                  hdr_len;

  function automatic shdlc_pkg::result_t summary_of(logic [7:0] addr, logic [7:0] cmd,
                                                    logic [7:0] state, logic [7:0] len,
                                                    shdlc_pkg::frame_status_t status);
    shdlc_pkg::result_t r;
    r.item_kind      = shdlc_pkg::KIND_SUMMARY;
    r.data_byte      = shdlc_pkg::ZERO_BYTE;
    r.slave_address  = addr;
    r.command_id     = cmd;
    r.device_state   = state;
    r.payload_length = len;
    r.frame_status   = status;
    return r;
  endfunction

  function automatic void reset_frame();
    esc_wait  = 1'b0;
    open_good = 1'b0;
    ucount    = '0;
    csum_acc  = '0;
    last_byte = '0;
    hdr_addr  = '0;
    hdr_cmd   = '0;
    hdr_state = '0;
    hdr_len   = '0;
  endfunction

  // One unstuffed byte: data goes out one byte late, headers are captured
  function automatic void take_unstuffed(logic [7:0] b);
    shdlc_pkg::result_t r;
    int                 pos;
    if (ucount != '0) begin
      pos = int'(ucount) - 1;
      if (pos >= 4 && pos < 4 + int'(hdr_len)) begin
        r              = '0;
        r.item_kind    = shdlc_pkg::KIND_DATA;
        r.data_byte    = last_byte;
        r.frame_status = shdlc_pkg::ST_OK;
        step_results.insert(step_results.size(), r);
      end
    end
    case (ucount)
      10'd0:   hdr_addr  = b;
      10'd1:   hdr_cmd   = b;
      10'd2:   hdr_state = b;
      10'd3:   hdr_len   = b;
      default: ;
    endcase
    csum_acc  = csum_acc + b;
    last_byte = b;
    if (ucount != shdlc_pkg::CNT_MAX) ucount = ucount + 1'b1;
  endfunction

  // Expected results of one raw byte, left in step_results
  function automatic void predict_results(logic [7:0] rx, logic fend);
    logic [7:0]               inv_sum;
    shdlc_pkg::frame_status_t status;
    step_results.delete();
    if (!framing) begin
      reset_frame();
      open_good = (rx == shdlc_pkg::FLAG_BYTE);
      framing   = 1'b1;
      if (!fend) return;
    end else if (!fend) begin
      if (esc_wait) begin
        esc_wait = 1'b0;
        case (rx)
          shdlc_pkg::ESC_FLAG: take_unstuffed(shdlc_pkg::FLAG_BYTE);
          shdlc_pkg::ESC_ESC:  take_unstuffed(shdlc_pkg::ESC_BYTE);
          shdlc_pkg::ESC_XON:  take_unstuffed(shdlc_pkg::DC1_BYTE);
          shdlc_pkg::ESC_XOFF: take_unstuffed(shdlc_pkg::DC3_BYTE);
          default: begin
            // unknown escape: the 7D stands as a plain byte
            take_unstuffed(shdlc_pkg::ESC_BYTE);
            if (rx == shdlc_pkg::ESC_BYTE) esc_wait = 1'b1;
            else take_unstuffed(rx);
          end
        endcase
      end else if (rx == shdlc_pkg::ESC_BYTE) begin
        esc_wait = 1'b1;
      end else begin
        take_unstuffed(rx);
      end
      return;
    end else if (esc_wait) begin
      // escape still open at the closing byte
      esc_wait = 1'b0;
      take_unstuffed(shdlc_pkg::ESC_BYTE);
    end
    inv_sum = (csum_acc - last_byte) ^ shdlc_pkg::INV_MASK;
    if (!open_good || rx != shdlc_pkg::FLAG_BYTE) status = shdlc_pkg::ST_BAD_DELIM;
    else if (int'(ucount) < 5 + int'(hdr_len)) status = shdlc_pkg::ST_SHORT;
    else if (inv_sum != last_byte) status = shdlc_pkg::ST_CSUM;
    else if (hdr_state != shdlc_pkg::ZERO_BYTE) status = shdlc_pkg::ST_DEV_STATE;
    else status = shdlc_pkg::ST_OK;
    step_results.insert(step_results.size(),
                        summary_of(hdr_addr, hdr_cmd, hdr_state, hdr_len, status));
    framing  = 1'b0;
    esc_wait = 1'b0;
  endfunction

  // Mostly short pauses, a few long ones
  function automatic int pause_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 8);
    else return $urandom_range(10, 40);
  endfunction

  // Random byte weighted towards framing and escape values
  function automatic logic [7:0] biased_byte();
    case ($urandom_range(0, 11))
      0:       return shdlc_pkg::FLAG_BYTE;
      1:       return shdlc_pkg::ESC_BYTE;
      2:       return shdlc_pkg::DC1_BYTE;
      3:       return shdlc_pkg::DC3_BYTE;
      4:       return shdlc_pkg::ZERO_BYTE;
      5:       return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  // Drive one byte, wait for the transaction, queue what it should produce
  task automatic send_byte(input logic [7:0] rx, input logic fend,
                           input bit typed = 1'b0, input shdlc_pkg::result_t want = '0);
    int gap;
    gap = (quiet_mode || $urandom_range(0, 99) < 55) ? 0 : pause_length();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.rx_byte   <= rx;
    in_chan.frame_end <= fend;
    do begin
      @(posedge clk);
    end while (in_chan.ready !== 1'b1);
    predict_results(rx, fend);
    if (typed) awaited_results.insert(awaited_results.size(), want);
    else foreach (step_results[i]) awaited_results.insert(awaited_results.size(),
                                                          step_results[i]);
    items_sent++;
  endtask

  // Sender idles until every awaited result has come out
  task automatic wait_for_drain();
    in_chan.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (awaited_results.size() != 0);
  endtask

  // One response frame: header, data, checksum, stuffed, with an optional fault
  task automatic send_frame();
    logic [7:0] body[$];
    logic [7:0] line[$];
    logic [7:0] acc;
    logic [7:0] len;
    int         ndata;
    int         fault;
    int         keep;
    int         r;
    body.insert(body.size(), biased_byte());
    body.insert(body.size(), biased_byte());
    body.insert(body.size(),
                ($urandom_range(0, 99) < 75) ? shdlc_pkg::ZERO_BYTE : biased_byte());
    r = $urandom_range(0, 99);
    if (r < 85) len = 8'($urandom_range(0, 6));
    else if (r < 97) len = 8'($urandom_range(7, 20));
    else len = 8'($urandom_range(21, 255));
    body.insert(body.size(), len);
    ndata = int'(len);
    fault = $urandom_range(0, 99);
    // surplus or missing data bytes
    if (fault < 10) begin
      ndata += $urandom_range(1, 3);
    end else if (fault < 20) begin
      ndata -= $urandom_range(1, 3);
      if (ndata < 0) ndata = 0;
    end
    repeat (ndata) body.insert(body.size(), biased_byte());
    acc = '0;
    foreach (body[i]) acc += body[i];
    body.insert(body.size(), acc ^ shdlc_pkg::INV_MASK);
    if (fault >= 20 && fault < 30) body[body.size()-1] ^= 8'(1 << $urandom_range(0, 7));
    // byte stuffing, with the odd stray escape
    foreach (body[i]) begin
      if ($urandom_range(0, 99) < 3) line.insert(line.size(), shdlc_pkg::ESC_BYTE);
      case (body[i])
        shdlc_pkg::FLAG_BYTE: begin
          line.insert(line.size(), shdlc_pkg::ESC_BYTE);
          line.insert(line.size(), shdlc_pkg::ESC_FLAG);
        end
        shdlc_pkg::ESC_BYTE: begin
          line.insert(line.size(), shdlc_pkg::ESC_BYTE);
          line.insert(line.size(), shdlc_pkg::ESC_ESC);
        end
        shdlc_pkg::DC1_BYTE: begin
          if ($urandom_range(0, 1) == 0) line.insert(line.size(), shdlc_pkg::ESC_BYTE);
          line.insert(line.size(), ($urandom_range(0, 1) == 0) ? shdlc_pkg::ESC_XON
                                                                : shdlc_pkg::DC1_BYTE);
        end
        shdlc_pkg::DC3_BYTE: begin
          if ($urandom_range(0, 1) == 0) line.insert(line.size(), shdlc_pkg::ESC_BYTE);
          line.insert(line.size(), ($urandom_range(0, 1) == 0) ? shdlc_pkg::ESC_XOFF
                                                                : shdlc_pkg::DC3_BYTE);
        end
        default: line.insert(line.size(), body[i]);
      endcase
    end
    // truncated frame, sometimes cut right after an escape
    if (fault >= 44 && fault < 52) begin
      keep = $urandom_range(0, line.size());
      while (line.size() > keep) void'(line.pop_back());
      if ($urandom_range(0, 2) == 0) line.insert(line.size(), shdlc_pkg::ESC_BYTE);
    end
    send_byte((fault >= 30 && fault < 38) ? biased_byte() : shdlc_pkg::FLAG_BYTE, 1'b0);
    foreach (line[i]) send_byte(line[i], 1'b0);
    send_byte((fault >= 38 && fault < 44) ? biased_byte() : shdlc_pkg::FLAG_BYTE, 1'b1);
  endtask

  // Stimulus
  initial begin
    stim_row_t rows [DIRECTED_ROWS];
    bit        pressed;
    int        n;
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.rx_byte   <= '0;
    in_chan.frame_end <= 1'b0;
    framing = 1'b0;
    reset_frame();
    rows = '{
      // lone byte as both delimiters
      '{shdlc_pkg::ZERO_BYTE, 1'b1, 1'b1,
        summary_of(shdlc_pkg::ZERO_BYTE, shdlc_pkg::ZERO_BYTE, shdlc_pkg::ZERO_BYTE,
                   shdlc_pkg::ZERO_BYTE, shdlc_pkg::ST_BAD_DELIM)},
      '{shdlc_pkg::FLAG_BYTE, 1'b1, 1'b1,
        summary_of(shdlc_pkg::ZERO_BYTE, shdlc_pkg::ZERO_BYTE, shdlc_pkg::ZERO_BYTE,
                   shdlc_pkg::ZERO_BYTE, shdlc_pkg::ST_SHORT)},
      // shortest good frame, all-zero header
      '{shdlc_pkg::FLAG_BYTE, 1'b0, 1'b0, '0},
      '{shdlc_pkg::ZERO_BYTE, 1'b0, 1'b0, '0},
      '{shdlc_pkg::ZERO_BYTE, 1'b0, 1'b0, '0},
      '{shdlc_pkg::ZERO_BYTE, 1'b0, 1'b0, '0},
      '{shdlc_pkg::ZERO_BYTE, 1'b0, 1'b0, '0},
      '{8'hFF,                1'b0, 1'b0, '0},
      '{shdlc_pkg::FLAG_BYTE, 1'b1, 1'b1,
        summary_of(shdlc_pkg::ZERO_BYTE, shdlc_pkg::ZERO_BYTE, shdlc_pkg::ZERO_BYTE,
                   shdlc_pkg::ZERO_BYTE, shdlc_pkg::ST_OK)},
      // every escape, double escape, unknown escape, escape open at the end
      '{shdlc_pkg::FLAG_BYTE, 1'b0, 1'b0, '0},
      '{8'hFF,                1'b0, 1'b0, '0},
      '{8'h01,                1'b0, 1'b0, '0},
      '{8'h03,                1'b0, 1'b0, '0},
      '{8'h05,                1'b0, 1'b0, '0},
      '{shdlc_pkg::ESC_BYTE,  1'b0, 1'b0, '0},
      '{shdlc_pkg::ESC_FLAG,  1'b0, 1'b0, '0},
      '{shdlc_pkg::ESC_BYTE,  1'b0, 1'b0, '0},
      '{shdlc_pkg::ESC_ESC,   1'b0, 1'b0, '0},
      '{shdlc_pkg::ESC_BYTE,  1'b0, 1'b0, '0},
      '{shdlc_pkg::ESC_XON,   1'b0, 1'b0, '0},
      '{shdlc_pkg::ESC_BYTE,  1'b0, 1'b0, '0},
      '{shdlc_pkg::ESC_XOFF,  1'b0, 1'b0, '0},
      '{shdlc_pkg::ESC_BYTE,  1'b0, 1'b0, '0},
      '{shdlc_pkg::ESC_BYTE,  1'b0, 1'b0, '0},
      '{shdlc_pkg::ESC_BYTE,  1'b0, 1'b0, '0},
      '{8'h41,                1'b0, 1'b0, '0},
      '{shdlc_pkg::ESC_BYTE,  1'b0, 1'b0, '0},
      '{shdlc_pkg::FLAG_BYTE, 1'b1, 1'b0, '0}
    };
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) send_byte(rows[i].rx, rows[i].fend, rows[i].typed, rows[i].want);

    // random frames with noise in between
    pressed = 1'b0;
    while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
      quiet_mode = ($urandom_range(0, 99) < 15);
      if (!pressed && items_sent >= DIRECTED_ROWS + RANDOM_ITEMS / 2) begin
        // hold the sender off until every awaited result is in
        pressed = 1'b1;
        wait_for_drain();
      end
      if ($urandom_range(0, 99) < 88) begin
        send_frame();
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) send_byte(biased_byte(), $urandom_range(0, 99) < 20);
        if ($urandom_range(0, 99) < 80) send_byte(biased_byte(), 1'b1);
      end
    end

    // a single long frame can jump past the midpoint; pause before one more
    quiet_mode = 1'b0;
    if (!pressed) begin
      pressed = 1'b1;
      wait_for_drain();
      send_frame();
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result side back-pressure
  initial begin
    int stall_left;
    out_chan.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 99) < 20) begin
        stall_left = pause_length() - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  task automatic compare_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%02h, got 0x%02h", field, want, got);
      mismatches++;
    end
  endtask

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    shdlc_pkg::result_t want;
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (awaited_results.size() == 0) begin
        $error("result with none awaited: kind %0d data 0x%02h status %0d",
               out_chan.item_kind, out_chan.data_byte, out_chan.frame_status);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        compare_field("item_kind", 8'(want.item_kind), 8'(out_chan.item_kind));
        compare_field("data_byte", want.data_byte, out_chan.data_byte);
        compare_field("slave_address", want.slave_address, out_chan.slave_address);
        compare_field("command_id", want.command_id, out_chan.command_id);
        compare_field("device_state", want.device_state, out_chan.device_state);
        compare_field("payload_length", want.payload_length, out_chan.payload_length);
        compare_field("frame_status", 8'(want.frame_status), 8'(out_chan.frame_status));
      end
    end
  end

  // Watchdog: too long without any transaction
  initial begin
    wait (rst_n === 1'b1);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
          (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule
